@@ sv/rse_pkg.sv @@
`timescale 1ns / 1ps

package rse_pkg;

   // token opcodes as they arrive on the request channel
   localparam logic [2:0] OPC_PUSH = 3'd0;
   localparam logic [2:0] OPC_ADD  = 3'd1;
   localparam logic [2:0] OPC_SUB  = 3'd2;
   localparam logic [2:0] OPC_MUL  = 3'd3;
   localparam logic [2:0] OPC_DIV  = 3'd4;

   // status codes on the response channel
   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_UNDER = 2'd1;
   localparam logic [1:0] STS_OVER  = 2'd2;
   localparam logic [1:0] STS_DIVZ  = 2'd3;

   // width used to sign-extend words before they are cut to the port width
   localparam int EXT_WIDTH = 64;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH_B,
      ST_FETCH_A,
      ST_CALC,
      ST_READ_TOP,
      ST_LOAD
   } seq_state_type;

endpackage

@@ sv/rse_stack.sv @@
`timescale 1ns / 1ps

module rse_stack #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] stack_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stack_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rse_alu.sv @@
`timescale 1ns / 1ps

module rse_alu #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rse_pkg::alu_ctrl_type  ctrl,
   input  logic [WORD_WIDTH-1:0]  opnd_a,
   input  logic [WORD_WIDTH-1:0]  opnd_b,
   output logic                   done,
   output logic [WORD_WIDTH-1:0]  result
);

   import rse_pkg::*;

   localparam int CNT_W = $clog2(WORD_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   alu_op_type            op_ff, op_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] opa_ff, opa_in;
   logic [WORD_WIDTH-1:0] opb_ff, opb_in;

   logic [WORD_WIDTH:0]   add_x;
   logic [WORD_WIDTH:0]   add_y;
   logic                  add_cin;
   logic [WORD_WIDTH+1:0] add_sum;
   logic                  add_carry;
   logic [WORD_WIDTH-1:0] abs_a;
   logic [WORD_WIDTH-1:0] abs_b;

   // the one adder shared by every operation
   always_comb begin
      add_x   = {1'b0, acc_ff};
      add_y   = {1'b0, opb_ff};
      add_cin = 1'b0;
      case (op_ff)
         ALU_SUB: begin
            add_y   = {1'b0, ~opb_ff};
            add_cin = 1'b1;
         end
         ALU_MUL: begin
            add_y = {1'b0, opa_ff};
         end
         ALU_DIV: begin
            // trial subtract of the divisor from the shifted partial remainder
            add_x   = {acc_ff, opa_ff[WORD_WIDTH-1]};
            add_y   = ~{1'b0, opb_ff};
            add_cin = 1'b1;
         end
         default: begin
         end
      endcase
      add_sum   = {1'b0, add_x} + {1'b0, add_y} + (WORD_WIDTH + 2)'(add_cin);
      add_carry = add_sum[WORD_WIDTH+1];
   end

   assign abs_a = opnd_a[WORD_WIDTH-1] ? (~opnd_a + WORD_WIDTH'(1)) : opnd_a;
   assign abs_b = opnd_b[WORD_WIDTH-1] ? (~opnd_b + WORD_WIDTH'(1)) : opnd_b;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         op_in   = ctrl.op;
         neg_in  = opnd_a[WORD_WIDTH-1] ^ opnd_b[WORD_WIDTH-1];
         case (ctrl.op)
            ALU_MUL: begin
               cnt_in = CNT_W'(WORD_WIDTH);
               acc_in = '0;
               opa_in = opnd_a;
               opb_in = opnd_b;
            end
            ALU_DIV: begin
               cnt_in = CNT_W'(WORD_WIDTH);
               acc_in = '0;
               opa_in = abs_a;
               opb_in = abs_b;
            end
            default: begin
               cnt_in = CNT_W'(1);
               acc_in = opnd_a;
               opb_in = opnd_b;
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            ALU_MUL: begin
               if (opb_ff[0]) begin
                  acc_in = add_sum[WORD_WIDTH-1:0];
               end
               opa_in = {opa_ff[WORD_WIDTH-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[WORD_WIDTH-1:1]};
            end
            ALU_DIV: begin
               // restore when the trial went negative, quotient bit shifts in
               acc_in = add_carry ? add_sum[WORD_WIDTH-1:0]
                                  : {acc_ff[WORD_WIDTH-2:0], opa_ff[WORD_WIDTH-1]};
               opa_in = {opa_ff[WORD_WIDTH-2:0], add_carry};
            end
            default: begin
               acc_in = add_sum[WORD_WIDTH-1:0];
            end
         endcase
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == ALU_DIV) ? (neg_ff ? (~opa_ff + WORD_WIDTH'(1)) : opa_ff)
                                      : acc_ff;

endmodule

@@ sv/rpn_stack_evaluator_top.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_opcode, req_number, req_last_token
// rsp      out        rsp_valid/rsp_ready  rsp_top_value, rsp_status, rsp_expression_done
//
// push, ignored and faulted tokens never start the alu; the other operators do, and
// multiply and divide are paced by the bit-per-cycle shared alu.
// the stack memory has one registered read port, so operands and the new top
// are fetched one per cycle. reset empties the stack; the memory is not cleared.
// a new token is taken while the previous response still waits on rsp_ready;
// that token then holds in its last state until the older response transfers.

module rpn_stack_evaluator_top #(
   parameter int STACK_DEPTH = 16,
   parameter int WORD_WIDTH  = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_number,
   input  logic               req_last_token,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_top_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_expression_done
);

   import rse_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   seq_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [2:0]            op_ff, op_in;
   logic [WORD_WIDTH-1:0] num_ff, num_in;
   logic                  last_ff, last_in;
   logic [1:0]            status_ff, status_in;
   logic [WORD_WIDTH-1:0] b_ff, b_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_top_ff, rsp_top_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic [CNT_W-1:0]      cnt_m1;
   logic [CNT_W-1:0]      cnt_m2;
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [WORD_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [WORD_WIDTH-1:0] mem_rd_data;

   alu_ctrl_type          alu_ctrl;
   logic                  alu_done;
   logic [WORD_WIDTH-1:0] alu_result;

   logic signed [EXT_WIDTH-1:0] top_ext;

   rse_stack #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (WORD_WIDTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rse_alu #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opnd_a (mem_rd_data),
      .opnd_b (b_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign cnt_m1  = count_ff - CNT_W'(1);
   assign cnt_m2  = count_ff - CNT_W'(2);
   assign top_ext = EXT_WIDTH'(signed'(mem_rd_data));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      num_in        = num_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      b_in          = b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_top_in    = rsp_top_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[ADDR_W-1:0];
      mem_wr_data   = num_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = cnt_m1[ADDR_W-1:0];
      alu_ctrl      = '{start: 1'b0, op: ALU_ADD};
      req_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_opcode;
               num_in    = WORD_WIDTH'(EXT_WIDTH'(req_number));
               last_in   = req_last_token;
               status_in = STS_OK;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (op_ff)
               OPC_PUSH: begin
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     status_in = STS_OVER;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end
                  state_in = ST_READ_TOP;
               end
               OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
                  if (count_ff < CNT_W'(2)) begin
                     status_in = STS_UNDER;
                     state_in  = ST_READ_TOP;
                  end else begin
                     // top of stack first
                     mem_rd_en = 1'b1;
                     state_in  = ST_FETCH_B;
                  end
               end
               default: begin
                  state_in = ST_READ_TOP;
               end
            endcase
         end
         ST_FETCH_B: begin
            b_in        = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = cnt_m2[ADDR_W-1:0];
            state_in    = ST_FETCH_A;
         end
         ST_FETCH_A: begin
            if ((op_ff == OPC_DIV) && (b_ff == '0)) begin
               status_in = STS_DIVZ;
               state_in  = ST_READ_TOP;
            end else begin
               alu_ctrl.start = 1'b1;
               case (op_ff)
                  OPC_SUB: alu_ctrl.op = ALU_SUB;
                  OPC_MUL: alu_ctrl.op = ALU_MUL;
                  OPC_DIV: alu_ctrl.op = ALU_DIV;
                  default: alu_ctrl.op = ALU_ADD;
               endcase
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (alu_done) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cnt_m2[ADDR_W-1:0];
               mem_wr_data = alu_result;
               count_in    = cnt_m1;
               state_in    = ST_READ_TOP;
            end
         end
         ST_READ_TOP: begin
            mem_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            // wait until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (count_ff == '0) ? '0 : 32'(top_ext);
               rsp_status_in = status_ff;
               rsp_done_in   = last_ff;
               if (last_ff) begin
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      num_ff        <= num_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      b_ff          <= b_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_top_value       = rsp_top_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_expression_done = rsp_done_ff;

endmodule

@@ tb/rse_result_checker.sv @@
`timescale 1ns / 1ps

module rse_result_checker #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_number,
   input  logic        req_last_token,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_top_value,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_expression_done,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);

   import rse_pkg::*;

   typedef struct packed {
      logic [31:0] top_value;
      logic [1:0]  status;
      logic        done;
   } token_result_type;

   logic [31:0]      eval_stack [STACK_DEPTH];
   int               eval_depth = 0;
   token_result_type expected_results [$];
   int               mismatches = 0;
   int               responses = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
   end

   function automatic logic [31:0] divide_toward_zero(input logic [31:0] a,
                                                      input logic [31:0] b);
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic [31:0] quot;
      mag_a = a[31] ? -a : a;
      mag_b = b[31] ? -b : b;
      quot  = mag_a / mag_b;
      // most negative over minus one wraps back to itself here
      return (a[31] ^ b[31]) ? -quot : quot;
   endfunction

   // applies one token to the local stack and forms its response
   function automatic token_result_type evaluate_token(input logic [2:0]  opc,
                                                       input logic [31:0] num,
                                                       input logic        last);
      token_result_type res;
      logic [31:0]      lhs;
      logic [31:0]      rhs;
      logic [31:0]      val;
      logic             apply;
      res.status = STS_OK;
      case (opc)
         OPC_PUSH: begin
            if (eval_depth >= STACK_DEPTH) begin
               res.status = STS_OVER;
            end else begin
               eval_stack[eval_depth] = num;
               eval_depth++;
            end
         end
         OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
            if (eval_depth < 2) begin
               res.status = STS_UNDER;
            end else begin
               rhs   = eval_stack[eval_depth - 1];
               lhs   = eval_stack[eval_depth - 2];
               val   = '0;
               apply = 1'b1;
               case (opc)
                  OPC_ADD: val = lhs + rhs;
                  OPC_SUB: val = lhs - rhs;
                  OPC_MUL: val = lhs * rhs;
                  default: begin
                     if (rhs == '0) begin
                        res.status = STS_DIVZ;
                        apply      = 1'b0;
                     end else begin
                        val = divide_toward_zero(lhs, rhs);
                     end
                  end
               endcase
               if (apply) begin
                  eval_depth--;
                  eval_stack[eval_depth - 1] = val;
               end
            end
         end
         default: ; // spare opcodes leave the stack alone
      endcase
      res.top_value = (eval_depth == 0) ? '0 : eval_stack[eval_depth - 1];
      res.done      = last;
      // clearing happens even when the token itself was refused
      if (last)
         eval_depth = 0;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      token_result_type want;
      if (reset) begin
         eval_depth = 0;
         expected_results.delete();
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(evaluate_token(req_opcode, req_number,
                                                      req_last_token));
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response %0d with nothing outstanding: top %0d",
                                         responses, $signed(rsp_top_value)));
            end else begin
               want = expected_results.pop_front();
               if (rsp_top_value !== want.top_value || rsp_status !== want.status ||
                   rsp_expression_done !== want.done)
                  report_mismatch($sformatf(
                     "response %0d: top %0d want %0d, status %0d want %0d, done %0b want %0b",
                     responses, $signed(rsp_top_value), $signed(want.top_value),
                     rsp_status, want.status, rsp_expression_done, want.done));
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_results.size();
      checked_count  <= responses;
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   import rse_pkg::*;

   localparam int STACK_DEPTH    = 16;
   localparam int TOTAL_TOKENS   = 1500;
   localparam int HOLD_AT        = 500;
   localparam int PAUSE_AT       = 900;
   localparam int CALM_FROM      = 1300;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic [2:0]  OPC_SPARE = 3'd5;
   localparam logic [31:0] WORD_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_opcode;
   logic signed [31:0] req_number;
   logic               req_last_token;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_top_value;
   logic [1:0]         rsp_status;
   logic               rsp_expression_done;

   int mismatch_count;
   int pending_count;
   int checked_count;

   int tokens_sent      = 0;
   int expressions_sent = 0;
   int idle_cycles      = 0;
   bit calm             = 1'b0;
   bit hold_request     = 1'b0;

   rpn_stack_evaluator_top #(
      .STACK_DEPTH (STACK_DEPTH),
      .WORD_WIDTH  (32)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_number          (req_number),
      .req_last_token      (req_last_token),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_top_value       (rsp_top_value),
      .rsp_status          (rsp_status),
      .rsp_expression_done (rsp_expression_done)
   );

   rse_result_checker #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_number          (req_number),
      .req_last_token      (req_last_token),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_top_value       (rsp_top_value),
      .rsp_status          (rsp_status),
      .rsp_expression_done (rsp_expression_done),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count),
      .checked_count       (checked_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ends the run with FAIL when nothing transfers on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   // response side: random back-pressure, one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0:       return WORD_MAX;
               1:       return WORD_MIN;
               2:       return ALL_ONES;
               3:       return '0;
               default: return 32'd1;
            endcase
         end
         1, 2, 3: return 32'($urandom_range(0, 40) - 20);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_token(input logic [2:0] opc, input logic [31:0] num,
                             input logic last);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= opc;
      req_number     <= num;
      req_last_token <= last;
      do @(posedge clock); while (!req_ready);
      tokens_sent++;
   endtask

   // mostly well-formed expressions, a few stray tokens, sometimes a deep one
   task automatic drive_expression();
      int         len;
      int         depth;
      int         push_pct;
      logic [2:0] opc;
      len      = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      push_pct = ($urandom_range(0, 7) == 0) ? 90 : 50;
      depth    = 0;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 99) < 6)
            opc = 3'($urandom_range(0, 7));
         else if (depth < 2 || $urandom_range(0, 99) < push_pct)
            opc = OPC_PUSH;
         else
            opc = 3'($urandom_range(OPC_ADD, OPC_DIV));
         if (opc == OPC_PUSH && depth < STACK_DEPTH)
            depth++;
         else if (opc >= OPC_ADD && opc <= OPC_DIV && depth >= 2)
            depth--;
         send_token(opc, pick_operand(), k == len - 1);
      end
      expressions_sent++;
   endtask

   initial begin
      bit held;
      bit paused;
      held   = 1'b0;
      paused = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= OPC_PUSH;
      req_number     <= '0;
      req_last_token <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // operator on an empty stack
      send_token(OPC_SUB, WORD_MAX, 1'b0);
      // most negative over minus one
      send_token(OPC_PUSH, WORD_MIN, 1'b0);
      send_token(OPC_PUSH, ALL_ONES, 1'b0);
      send_token(OPC_DIV, '0, 1'b0);
      // divide by zero, refused but still clears as the last token
      send_token(OPC_PUSH, '0, 1'b0);
      send_token(OPC_DIV, ALL_ONES, 1'b1);
      // fill the stack, the top three set up wrapping add and multiply
      for (int i = 0; i < STACK_DEPTH; i++)
         send_token(OPC_PUSH, (i == 13) ? ALL_ONES : (i == 14) ? WORD_MAX :
                              (i == 15) ? 32'd1 : $urandom(), 1'b0);
      send_token(OPC_PUSH, WORD_MIN, 1'b0);
      send_token(OPC_ADD, '0, 1'b0);
      send_token(OPC_MUL, '0, 1'b0);
      send_token(OPC_SPARE, ALL_ONES, 1'b1);
      expressions_sent = 2;

      while (tokens_sent < TOTAL_TOKENS) begin
         calm = (tokens_sent >= CALM_FROM);
         if (!held && tokens_sent >= HOLD_AT) begin
            hold_request = 1'b1;
            held         = 1'b1;
         end
         if (!paused && tokens_sent >= PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
            paused = 1'b1;
         end
         drive_expression();
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d tokens in %0d expressions driven, %0d responses checked, %0d mismatches",
               tokens_sent, expressions_sent, checked_count, mismatch_count);
      if (pending_count != 0)
         $display("%0d responses never arrived", pending_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
